// ----- rtl/dpr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_pkg: shared types and constants
// byte codes, command codes and the classified operation that the front
// hands to the back through the queue
// ----------------------------------------------------------------------------
package dpr_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int POS_W     = $clog2(BUF_DEPTH);
  localparam int IDX_W     = 7;
  localparam int QUEUE_DEPTH = 2;

  // command field codes
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // byte values of interest
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_ACK,
    OP_READ,
    OP_NONE
  } op_kind_t;

  typedef enum logic [2:0] {
    BC_CMD,
    BC_AT,
    BC_LF,
    BC_CR,
    BC_OTHER
  } byte_class_t;

  typedef struct packed {
    op_kind_t          kind;
    byte_class_t       cls;
    logic [7:0]        data;
    logic              rd_in_range;
    logic              rd_head;     // entry 0 or 1, held in flops
    logic              rd_head_sel; // which of the two head entries
    logic [POS_W-1:0]  rd_addr;
  } op_t;

endpackage
`default_nettype wire

// ----- rtl/dpr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_front: input acceptance and classification
// decodes command and byte class, range-checks the read index and pushes
// the classified operation into the queue
// ----------------------------------------------------------------------------
module dpr_front (
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       command,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [6:0]       read_index,
  input  wire logic             queue_full,
  output logic                  push,
  output dpr_pkg::op_t          push_op
);
  import dpr_pkg::*;

  logic [31:0] idx_wide;

  assign idx_wide = 32'(read_index);
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_op             = '0;
    push_op.data        = rx_byte;
    push_op.rd_in_range = idx_wide < 32'(BUF_DEPTH);
    push_op.rd_head     = idx_wide < 32'd2;
    push_op.rd_head_sel = read_index[0];
    push_op.rd_addr     = idx_wide[POS_W-1:0];

    unique case (command)
      CMD_BYTE: push_op.kind = OP_BYTE;
      CMD_ACK:  push_op.kind = OP_ACK;
      CMD_READ: push_op.kind = OP_READ;
      default:  push_op.kind = OP_NONE;
    endcase

    unique case (rx_byte) inside
      CH_ZERO, CH_ONE, CH_TWO, CH_H: push_op.cls = BC_CMD;
      CH_AT:   push_op.cls = BC_AT;
      CH_LF:   push_op.cls = BC_LF;
      CH_CR:   push_op.cls = BC_CR;
      default: push_op.cls = BC_OTHER;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/dpr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_queue: short operation queue
// two-entry fifo between front and back, push and pop in the same cycle
// ----------------------------------------------------------------------------
module dpr_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  dpr_pkg::op_t      push_op,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output dpr_pkg::op_t      head_op
);
  import dpr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

  // no overflow, no underflow
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + (PTR_W + 1)'(1))
    else $error("count did not follow push");

endmodule
`default_nettype wire

// ----- rtl/dpr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_back: packet assembly and result register
// executes one operation per cycle unless a result is stalled, owns the
// packet store and the receiver state, and holds the result until it is taken
// ----------------------------------------------------------------------------
module dpr_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         op_valid,
  input  dpr_pkg::op_t      op,
  output logic              op_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        read_byte,
  output logic              packet_ready,
  output logic              in_packet,
  output logic [31:0]       received_total
);
  import dpr_pkg::*;

  // receiver state
  logic             receiving;
  logic             ready;
  logic [POS_W-1:0] wpos;
  logic [31:0]      counter;

  // packet store: entries 0 and 1 in flops, the rest in memory
  logic [7:0]       head0;
  logic [7:0]       head1;
  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       mem_q;
  logic             rd_from_mem;
  logic [7:0]       rd_hold;

  logic             fire;
  logic             is_byte;
  logic             cmd_store;   // single-byte command taken
  logic             at_start;    // packet start taken
  logic             lf_end;      // terminator written
  logic             room;
  logic             append;      // byte appended in packet
  logic             overflow;
  logic             store_wr;    // write at wpos
  logic [7:0]       store_val;
  logic             mem_rd;

  assign fire    = op_valid && (!out_valid || !out_stall);
  assign op_pop  = fire;
  assign is_byte = fire && op.kind == OP_BYTE;
  assign room    = wpos < POS_W'(BUF_DEPTH - 1);

  assign cmd_store = is_byte && !receiving && !ready && op.cls == BC_CMD;
  assign at_start  = is_byte && !receiving && !ready && op.cls == BC_AT;
  assign lf_end    = is_byte && receiving && op.cls == BC_LF;
  assign append    = is_byte && receiving && op.cls != BC_LF && room && op.cls != BC_CR;
  assign overflow  = is_byte && receiving && op.cls != BC_LF && !room;
  assign store_wr  = lf_end || append;
  assign store_val = lf_end ? 8'd0 : op.data;
  assign mem_rd    = fire && op.kind == OP_READ && op.rd_in_range && !op.rd_head;

  always_ff @(posedge clk) begin
    if (store_wr && wpos != POS_W'(0) && wpos != POS_W'(1)) begin
      mem[wpos] <= store_val;
    end
    if (mem_rd) begin
      mem_q <= mem[op.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_store || at_start) begin
      head0 <= op.data;
    end
    if (cmd_store) begin
      head1 <= 8'd0;
    end else if (store_wr && wpos == POS_W'(1)) begin
      head1 <= store_val;
    end
    if (fire) begin
      rd_from_mem <= mem_rd;
      if (op.kind == OP_READ && op.rd_in_range && op.rd_head) begin
        rd_hold <= op.rd_head_sel ? head1 : head0;
      end else begin
        rd_hold <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving <= 1'b0;
      ready     <= 1'b0;
      wpos      <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (is_byte) begin
        counter <= counter + 32'd1;
      end
      if (at_start) begin
        receiving <= 1'b1;
        wpos      <= POS_W'(1);
      end else if (lf_end || overflow) begin
        receiving <= 1'b0;
      end else if (append) begin
        wpos <= wpos + POS_W'(1);
      end
      if (cmd_store || lf_end) begin
        ready <= 1'b1;
      end else if (fire && op.kind == OP_ACK) begin
        ready <= 1'b0;
      end
    end
  end

  // state only moves when a result is issued, so it doubles as the result
  assign read_byte      = rd_from_mem ? mem_q : rd_hold;
  assign packet_ready   = ready;
  assign in_packet      = receiving;
  assign received_total = counter;

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    receiving |-> wpos != '0) else $error("packet write position at zero");
  a_count_bytes: assert property (@(posedge clk) disable iff (rst)
    is_byte |=> counter == $past(counter) + 32'd1)
    else $error("byte count did not advance");
  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && op.kind == OP_ACK) |=> !ready) else $error("ack left ready set");
  a_ready_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ready) |-> $past(cmd_store || lf_end))
    else $error("ready set without a finished packet");

endmodule
`default_nettype wire

// ----- rtl/delimited_packet_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_packet_receiver: uart command packet assembler
// counts received bytes, collects '@' ... '\n' packets and single-byte
// commands into a byte store, and answers acknowledge and read requests
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with command, rx_byte, read_index.
//   command 0 delivers a received byte, 1 acknowledges the pending packet,
//   2 reads one store entry. every input transfer yields exactly one
//   result transfer on out_valid / out_stall carrying read_byte and the
//   state after the operation (packet_ready, in_packet, received_total).
//   an accepted transfer is written into the queue, then executed from
//   its head into the result register that drives the output channel.
//   throughput: one item per cycle while results are not stalled, set by
//   the execute step in the back end (one store write port, one registered read port).
//   a two-entry queue separates classification from execution; in_stall
//   rises only when that queue is full, so a stalled result still lets
//   up to two more items in before the input side stalls.
//   reset (rst, synchronous) empties the queue and the result register,
//   clears the counter, the ready mark and the packet state; the store
//   itself is not cleared and entries read before being written are
//   undefined.
// ----------------------------------------------------------------------------
module delimited_packet_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [6:0]  read_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic             packet_ready,
  output logic             in_packet,
  output logic [31:0]      received_total
);
  import dpr_pkg::*;

  // front to queue
  logic queue_full;
  logic push;
  op_t  push_op;

  // queue to back
  logic head_valid;
  op_t  head_op;
  logic pop;

  // classification of the incoming transfer
  dpr_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // decouples the two sides
  dpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // execution, packet store and result register
  dpr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (head_valid),
    .op             (head_op),
    .op_pop         (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .packet_ready   (packet_ready),
    .in_packet      (in_packet),
    .received_total (received_total)
  );

endmodule
`default_nettype wire

// ----- dv/delimited_packet_receiver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_packet_receiver_tb: self-checking bench for the packet receiver
// feeds received bytes, acknowledges and store reads through the input
// channel and checks every result transfer against a shadow model of the
// byte counter, the packet state machine and the byte store
// ----------------------------------------------------------------------------
module delimited_packet_receiver_tb;
  import dpr_pkg::*;

  localparam int N_ITEMS    = 1350;
  localparam int IDLE_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int TAIL_WAIT  = 10;    // cycles after the last result
  localparam int HOLD_AT    = 400;   // accepted transfers before the long stall
  localparam int HOLD_LEN   = 300;

  // command value the block must treat as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // shadow of everything the block keeps, plus which store entries hold data
  typedef struct packed {
    logic                      receiving;
    logic [POS_W-1:0]          wpos;
    logic                      ready;
    logic [BUF_DEPTH-1:0][7:0] store;
    logic [BUF_DEPTH-1:0]      written;
    logic [31:0]               total;
  } rx_state_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        ready;
    logic        inpkt;
    logic [31:0] total;
  } rx_result_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx;
    logic [6:0] idx;
    logic       pause;  // wait for all results before offering this one
  } stim_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_BYTE;
  logic [7:0] rx_byte = 8'h00;
  logic [6:0] read_index = 7'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_byte;
  logic       packet_ready;
  logic       in_packet;
  logic [31:0] received_total;

  stim_item_t pend_q[$];        // items not yet offered
  rx_result_t expected_q[$];    // results owed by the block, oldest first

  rx_state_t  gen_st;           // used while building stimulus
  rx_state_t  chk_st;           // advanced on every accepted transfer
  logic       pause_next = 1'b0;

  int         errors = 0;
  int         accepted_in = 0;
  int         idle_cycles = 0;
  bit         in_took = 1'b0;   // input transfer seen at the last rising edge

  delimited_packet_receiver u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .packet_ready   (packet_ready),
    .in_packet      (in_packet),
    .received_total (received_total)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow model
  // --------------------------------------------------------------------------

  // state after one input item
  function automatic rx_state_t rx_next(rx_state_t s, logic [1:0] cmd, logic [7:0] b);
    if (cmd == CMD_ACK) begin
      s.ready = 1'b0;
    end else if (cmd == CMD_BYTE) begin
      s.total = s.total + 32'd1;
      if (!s.receiving) begin
        if (b == CH_ZERO || b == CH_ONE || b == CH_TWO || b == CH_H) begin
          // single-byte command, only taken when nothing is pending
          if (!s.ready) begin
            s.store[0]   = b;
            s.store[1]   = 8'h00;
            s.written[0] = 1'b1;
            s.written[1] = 1'b1;
            s.ready      = 1'b1;
          end
        end else if (b == CH_AT) begin
          if (!s.ready) begin
            s.receiving  = 1'b1;
            s.store[0]   = b;
            s.written[0] = 1'b1;
            s.wpos       = POS_W'(1);
          end
        end
        // any other byte while idle is only counted
      end else if (b == CH_LF) begin
        s.receiving        = 1'b0;
        s.store[s.wpos]    = 8'h00;
        s.written[s.wpos]  = 1'b1;
        s.ready            = 1'b1;
      end else if (int'(s.wpos) < BUF_DEPTH - 1) begin
        if (b != CH_CR) begin
          s.store[s.wpos]   = b;
          s.written[s.wpos] = 1'b1;
          s.wpos            = s.wpos + POS_W'(1);
        end
      end else begin
        // store full: packet dropped, nothing marked ready
        s.receiving = 1'b0;
      end
    end
    return s;
  endfunction

  // result seen after the item, from the state after it
  function automatic rx_result_t rx_result(rx_state_t s, logic [1:0] cmd, logic [6:0] idx);
    rx_result_t r;
    r.rd    = (cmd == CMD_READ) ? s.store[idx] : 8'h00;
    r.ready = s.ready;
    r.inpkt = s.receiving;
    r.total = s.total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus building, tracked against gen_st so reads only hit written entries
  // --------------------------------------------------------------------------
  function automatic void put_item(logic [1:0] cmd, logic [7:0] b, logic [6:0] idx);
    stim_item_t it;
    it.cmd     = cmd;
    it.rx      = b;
    it.idx     = idx;
    it.pause   = pause_next;
    pause_next = 1'b0;
    pend_q.push_back(it);
    gen_st = rx_next(gen_st, cmd, b);
  endfunction

  function automatic void send_byte(logic [7:0] b);
    put_item(CMD_BYTE, b, 7'($urandom_range(0, 127)));
  endfunction

  function automatic void send_ack();
    put_item(CMD_ACK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endfunction

  // read a random entry that holds data, biased toward the packet head; with nothing written, an unused command instead
  function automatic void read_some();
    logic [6:0] i;
    if (gen_st.written == '0) begin
      put_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    end else begin
      do begin
        i = $urandom_range(0, 1) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(0, 127));
      end while (!gen_st.written[i]);
      put_item(CMD_READ, 8'($urandom_range(0, 255)), i);
    end
  endfunction

  // packet body byte: never a line feed, often one of the interesting codes
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = CH_CR;
      1: b = CH_AT;
      2: b = $urandom_range(0, 1) ? CH_ZERO : CH_H;
      3: b = $urandom_range(0, 1) ? CH_ONE : CH_TWO;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
      end
    endcase
    return b;
  endfunction

  // an ack if one is pending (mostly), '@', len body bytes, then a line feed or one more body byte
  function automatic void send_packet(int len, bit close_lf);
    if (gen_st.ready && $urandom_range(0, 9) != 0)
      send_ack();
    send_byte(CH_AT);
    for (int k = 0; k < len; k++)
      send_byte(body_byte());
    send_byte(close_lf ? CH_LF : body_byte());
  endfunction

  // '@' and just enough stored bytes to reach the last store entry,
  // then a line feed there or one byte too many
  function automatic void fill_packet(bit close_lf);
    logic [7:0] b;
    if (gen_st.ready)
      send_ack();
    send_byte(CH_AT);
    for (int k = 0; k < BUF_DEPTH - 2; k++) begin
      do b = body_byte(); while (b == CH_CR);
      send_byte(b);
    end
    send_byte(close_lf ? CH_LF : body_byte());
  endfunction

  function automatic logic [7:0] single_cmd();
    case ($urandom_range(0, 3))
      0:       return CH_ZERO;
      1:       return CH_ONE;
      2:       return CH_TWO;
      default: return CH_H;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // main sequence: build all stimulus, reset, then wait for the drain
  // --------------------------------------------------------------------------
  initial begin
    int r;
    int next_pause;
    gen_st = '0;
    chk_st = '0;

    // directed part
    put_item(CMD_UNUSED, 8'hFF, 7'h7F);   // unused command, nothing written yet
    send_ack();                           // acknowledge with nothing pending
    send_byte(8'h00);                     // other bytes while idle
    send_byte(8'hFF);
    send_byte(CH_ZERO);                   // single command marks ready
    put_item(CMD_READ, 8'h00, 7'd0);
    put_item(CMD_READ, 8'hFF, 7'd1);
    send_byte(CH_TWO);                    // command while pending: ignored
    send_byte(CH_AT);                     // start while pending: ignored
    send_ack();
    send_byte(CH_H);
    send_ack();
    send_byte(CH_ONE);
    send_ack();
    send_byte(CH_TWO);
    send_ack();
    send_byte(CH_AT);                     // packet with cr and ack inside
    send_byte(8'h41);
    send_byte(CH_CR);
    send_ack();                           // ack during reception keeps going
    send_byte(8'hFF);
    send_byte(CH_LF);
    put_item(CMD_READ, 8'h00, 7'd2);
    put_item(CMD_READ, 8'h00, 7'd3);
    send_ack();

    // a packet that fills the store exactly and one that overflows it
    fill_packet(1'b1);
    put_item(CMD_READ, 8'h00, 7'(BUF_DEPTH - 1));
    read_some();
    fill_packet(1'b0);
    read_some();

    // random part
    next_pause = 300;
    while (pend_q.size() < N_ITEMS) begin
      if (pend_q.size() >= next_pause) begin
        pause_next = 1'b1;
        next_pause += 400;
      end
      r = $urandom_range(0, 19);
      if (r <= 8) begin
        // well-formed packet, mostly short
        send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 10),
                    1'b1);
        repeat ($urandom_range(0, 4)) read_some();
        if ($urandom_range(0, 3) != 0)
          send_ack();
      end else if (r <= 11) begin
        if (gen_st.ready && $urandom_range(0, 7) != 0)
          send_ack();
        send_byte(single_cmd());
        repeat ($urandom_range(0, 2)) read_some();
      end else if (r <= 14) begin
        // unterminated packet, left for whatever comes next
        send_packet($urandom_range(0, 8), 1'b0);
        if ($urandom_range(0, 1))
          send_ack();
      end else if (r <= 17) begin
        repeat ($urandom_range(1, 6)) begin
          case (2'($urandom_range(0, 3)))
            CMD_READ: read_some();
            CMD_ACK:  send_ack();
            CMD_BYTE: send_byte(8'($urandom_range(0, 255)));
            default:  put_item(CMD_UNUSED, 8'($urandom_range(0, 255)),
                               7'($urandom_range(0, 127)));
          endcase
        end
      end else if (r == 18) begin
        repeat ($urandom_range(1, 5)) read_some();
      end else if ($urandom_range(0, 3) == 0) begin
        // rare long packet near or past the store size
        send_packet($urandom_range(100, BUF_DEPTH - 2), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) read_some();
      end else begin
        send_packet($urandom_range(20, 70), 1'b1);
        read_some();
      end
    end

    // hold reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every item to be taken, every result to arrive, then a tail
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, changes on the falling edge
  // --------------------------------------------------------------------------
  int         burst_left = 1;
  int         gap_left = 0;
  stim_item_t drv_item;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled: payload holds
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pend_q.size() == 0 || (pend_q[0].pause && expected_q.size() != 0)) begin
      // out of items, or draining all results before a pause point
      in_valid <= 1'b0;
    end else begin
      drv_item = pend_q.pop_front();
      in_valid   <= 1'b1;
      command    <= drv_item.cmd;
      rx_byte    <= drv_item.rx;
      read_index <= drv_item.idx;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                 : $urandom_range(0, 3);
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern in segments, plus one long hold-off
  // --------------------------------------------------------------------------
  int seg_left = 0;
  int seg_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && accepted_in >= HOLD_AT) begin
      // long hold-off so the block fills and pushes back on the input
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      case (seg_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= seg_left[1];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on each input transfer, check each result transfer
  // --------------------------------------------------------------------------
  rx_result_t got;
  rx_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      in_took = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{rd: read_byte, ready: packet_ready, inpkt: in_packet,
                total: received_total};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result transfer: rd=%h rdy=%b pkt=%b total=%0d",
                     got.rd, got.ready, got.inpkt, got.total);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected rd=%h rdy=%b pkt=%b total=%0d,",
                        " got rd=%h rdy=%b pkt=%b total=%0d"},
                       want.rd, want.ready, want.inpkt, want.total,
                       got.rd, got.ready, got.inpkt, got.total);
          end
        end
      end

      in_took = in_valid && !in_stall;
      if (in_took) begin
        chk_st = rx_next(chk_st, command, rx_byte);
        expected_q.push_back(rx_result(chk_st, command, read_index));
        accepted_in++;
      end

      // watchdog on cycles with no transfer at all
      if (in_took || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

endmodule
